>>> hdl/bgm_pkg.sv
// Shared types and constants for the button gesture and mode controller.
package bgm_pkg;

    // Fixed field widths
    localparam int TIME_W    = 32;
    localparam int LEVEL_W   = 8;
    localparam int COLUMN_W  = 3;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int REM_W     = 16;
    localparam int CNT_W     = $clog2(TIME_W);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COMBO_HOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALONE_HOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_ON   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_GAP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REST       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HELD_LEVEL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOW_LEVEL = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_LEVEL = 3'd7;

    // Register reset values
    localparam logic [15:0]        RST_COMBO_HOLD = 16'd3000;
    localparam logic [15:0]        RST_ALONE_HOLD = 16'd3000;
    localparam logic [11:0]        RST_FLASH_ON   = 12'd120;
    localparam logic [11:0]        RST_BLINK_GAP  = 12'd120;
    localparam logic [13:0]        RST_REST       = 14'd900;
    localparam logic [LEVEL_W-1:0] RST_HELD_LEVEL = 8'd255;
    localparam logic [LEVEL_W-1:0] RST_GLOW_LEVEL = 8'd204;
    localparam logic [LEVEL_W-1:0] RST_REST_LEVEL = 8'd128;
    localparam logic [COLUMN_W-1:0] RST_COLUMN    = 3'd4;

    // Input beat
    typedef struct packed {
        logic              circle_btn;
        logic              square_btn;
        logic              minus_pressed;
        logic              plus_pressed;
        logic              game_active;
        logic [TIME_W-1:0] time_ms;
    } t_in_beat;

    // Output beat
    typedef struct packed {
        logic                mute_state;
        logic                menu_state;
        logic                bend_state;
        logic [COLUMN_W-1:0] haptic_column;
        logic [LEVEL_W-1:0]  led_level;
        logic                led_write;
        logic                mute_toggled;
        logic                menu_toggled;
        logic                bend_toggled;
    } t_out_beat;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic iterate;
        logic commit;
    } t_dp_cmd;

endpackage

>>> hdl/button_gesture_mode_controller.sv
// Top level of the button gesture and mode controller.
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one beat per scan
//   tick: button levels, game flag and millisecond timestamp.
//   Output channel (o_out_valid / i_out_ready / o_out_data) returns one beat per
//   input beat: mute, menu, bend and column state, LED level and toggle pulses.
//   Config port (i_cfg_we / i_cfg_idx / i_cfg_data) writes one register per
//   cycle; write only while no beat is in flight.
// Sequence:
//   Each accepted beat runs the bit-serial remainder that finds the mute blink
//   phase (one timestamp bit per cycle), then a commit that registers the
//   result. The block is ready again in the cycle after the commit, so it
//   takes no new beat until the last one has been committed.
//   The output register holds a finished beat while the next one is taken
//   and worked on; if the receiver stalls, the commit waits and no beat is
//   lost or repeated.
// Reset: synchronous, active low; config returns to defaults, gesture state
//   clears, the haptics column returns to 4 and the output channel empties.
module button_gesture_mode_controller import bgm_pkg::*; #(
    parameter int MAX_COLUMN = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_beat             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_beat            o_out_data
);

    t_dp_cmd cmd;

    bgm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    bgm_dp #(
        .MAX_COLUMN (MAX_COLUMN)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_out_data (o_out_data)
    );

endmodule

>>> hdl/bgm_ctrl.sv
// Sequencer: accepts a beat, runs the phase remainder, commits the tick.
module bgm_ctrl import bgm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             can_commit;

    assign can_commit  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = CNT_W'(TIME_W - 1);
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.iterate = 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_DONE: begin
                if (can_commit) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> hdl/bgm_dp.sv
// Datapath: config registers, gesture state, serial remainder and output register.
module bgm_dp import bgm_pkg::*; #(
    parameter int MAX_COLUMN = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_in_beat             i_in_data,
    input  t_dp_cmd              i_cmd,
    output t_out_beat            o_out_data
);

    localparam logic [COLUMN_W:0] COL_MAX = (COLUMN_W+1)'(MAX_COLUMN);
    localparam logic [COLUMN_W:0] COL_MIN = (COLUMN_W+1)'(1);

    // Configuration
    logic [15:0]        r_combo_hold, r_alone_hold;
    logic [11:0]        r_flash_on, r_blink_gap;
    logic [13:0]        r_rest;
    logic [LEVEL_W-1:0] r_held_level, r_glow_level, r_rest_level;

    // Gesture state
    logic                r_square_prev, r_long_seen;
    logic                r_minus_prev, r_plus_prev, r_combo_prev, r_alone_prev;
    logic                r_mute_latched, r_mute_on, r_menu_latched, r_menu_on, r_bend_on;
    logic [TIME_W-1:0]   r_combo_start, r_alone_start;
    logic [COLUMN_W-1:0] r_column;
    logic [LEVEL_W-1:0]  r_led_hold;

    // Latched beat, remainder unit, output register
    t_in_beat          r_in;
    logic [TIME_W-1:0] r_dvd;
    logic [REM_W-1:0]  r_rem;
    t_out_beat         r_out;

    // Pattern lengths
    logic [12:0]      unit_len;
    logic [REM_W-1:0] cycle_len, rem_try;

    assign unit_len  = 13'(r_flash_on) + 13'(r_blink_gap);
    assign cycle_len = REM_W'({unit_len, 1'b0}) + REM_W'(r_rest);
    assign rem_try   = {r_rem[REM_W-2:0], r_dvd[TIME_W-1]};

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_combo_hold <= RST_COMBO_HOLD;
            r_alone_hold <= RST_ALONE_HOLD;
            r_flash_on   <= RST_FLASH_ON;
            r_blink_gap  <= RST_BLINK_GAP;
            r_rest       <= RST_REST;
            r_held_level <= RST_HELD_LEVEL;
            r_glow_level <= RST_GLOW_LEVEL;
            r_rest_level <= RST_REST_LEVEL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COMBO_HOLD: r_combo_hold <= i_cfg_data;
                CFG_ALONE_HOLD: r_alone_hold <= i_cfg_data;
                CFG_FLASH_ON:   r_flash_on   <= i_cfg_data[11:0];
                CFG_BLINK_GAP:  r_blink_gap  <= i_cfg_data[11:0];
                CFG_REST:       r_rest       <= i_cfg_data[13:0];
                CFG_HELD_LEVEL: r_held_level <= i_cfg_data[LEVEL_W-1:0];
                CFG_GLOW_LEVEL: r_glow_level <= i_cfg_data[LEVEL_W-1:0];
                CFG_REST_LEVEL: r_rest_level <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Beat latch and restoring remainder, one dividend bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in  <= i_in_data;
            r_dvd <= i_in_data.time_ms;
            r_rem <= '0;
        end else if (i_cmd.iterate) begin
            r_dvd <= {r_dvd[TIME_W-2:0], 1'b0};
            r_rem <= (rem_try >= cycle_len) ? rem_try - cycle_len : rem_try;
        end
    end

    // Tick evaluation
    logic                combo, alone, now_sq, now_ci;
    logic [TIME_W-1:0]   now;
    logic                n_long_seen, n_mute_latched, n_mute_on, n_menu_latched, n_menu_on;
    logic                n_bend_on, n_minus_prev, n_plus_prev;
    logic [TIME_W-1:0]   n_combo_start, n_alone_start;
    logic [COLUMN_W:0]   col;
    logic [COLUMN_W-1:0] n_column;
    logic [LEVEL_W-1:0]  level, blink;
    logic [REM_W-1:0]    phase, phase2;
    logic                mt, nt, bt, wr;

    assign now_sq = r_in.square_btn;
    assign now_ci = r_in.circle_btn;
    assign now    = r_in.time_ms;
    assign combo  = now_ci && now_sq;
    assign alone  = now_sq && !now_ci;

    // Mute blink pattern from the remainder
    always_comb begin
        phase  = (cycle_len == '0) ? '0 : r_rem;
        phase2 = phase - REM_W'(unit_len);
        if (phase < REM_W'(unit_len)) begin
            blink = (phase < REM_W'(r_flash_on)) ? r_held_level : '0;
        end else if (phase2 < REM_W'(unit_len)) begin
            blink = (phase2 < REM_W'(r_flash_on)) ? r_held_level : '0;
        end else begin
            blink = r_rest_level;
        end
    end

    always_comb begin
        n_long_seen    = r_long_seen;
        n_mute_latched = r_mute_latched;
        n_mute_on      = r_mute_on;
        n_menu_latched = r_menu_latched;
        n_menu_on      = r_menu_on;
        n_bend_on      = r_bend_on;
        n_minus_prev   = r_minus_prev;
        n_plus_prev    = r_plus_prev;
        n_combo_start  = r_combo_start;
        n_alone_start  = r_alone_start;
        col            = {1'b0, r_column};
        level          = r_led_hold;
        mt             = 1'b0;
        nt             = 1'b0;
        bt             = 1'b0;
        wr             = 1'b0;
        if (!r_in.game_active) begin
            if (now_sq && !r_square_prev) begin
                n_long_seen = 1'b0;
            end
            // Two-button combo: mute
            if (combo && !r_combo_prev) begin
                n_combo_start  = now;
                n_mute_latched = 1'b0;
            end
            if (combo) begin
                n_long_seen = 1'b1;
                if (!n_mute_latched && (now - n_combo_start) >= TIME_W'(r_combo_hold)) begin
                    n_mute_latched = 1'b1;
                    n_mute_on      = !r_mute_on;
                    mt             = 1'b1;
                end
            end
            // Square alone: menu and haptics column
            if (alone && !r_alone_prev) begin
                n_alone_start  = now;
                n_menu_latched = 1'b0;
            end
            if (alone && !n_mute_on) begin
                if (!n_menu_latched && (now - n_alone_start) >= TIME_W'(r_alone_hold)) begin
                    n_menu_latched = 1'b1;
                    n_long_seen    = 1'b1;
                    n_menu_on      = !r_menu_on;
                    nt             = 1'b1;
                end
                if (r_in.minus_pressed && !r_minus_prev) begin
                    col = (col > COL_MIN) ? col - 1'b1 : COL_MIN;
                    col = (col > COL_MAX) ? COL_MAX : col;
                end
                if (r_in.plus_pressed && !r_plus_prev) begin
                    col = col + 1'b1;
                    col = (col > COL_MAX) ? COL_MAX : col;
                end
                n_minus_prev = r_in.minus_pressed;
                n_plus_prev  = r_in.plus_pressed;
            end
            // Short click: pitch bend
            if (!now_sq && r_square_prev && !n_long_seen && !n_mute_on) begin
                n_bend_on = !r_bend_on;
                bt        = 1'b1;
            end
            // LED level
            if (n_mute_on) begin
                level = blink;
            end else if (combo || now_sq) begin
                level = r_held_level;
            end else begin
                level = n_bend_on ? r_glow_level : '0;
            end
            wr = 1'b1;
        end
        n_column = col[COLUMN_W-1:0];
    end

    // State commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square_prev  <= 1'b0;
            r_long_seen    <= 1'b0;
            r_minus_prev   <= 1'b0;
            r_plus_prev    <= 1'b0;
            r_combo_prev   <= 1'b0;
            r_alone_prev   <= 1'b0;
            r_mute_latched <= 1'b0;
            r_mute_on      <= 1'b0;
            r_menu_latched <= 1'b0;
            r_menu_on      <= 1'b0;
            r_bend_on      <= 1'b0;
            r_combo_start  <= '0;
            r_alone_start  <= '0;
            r_column       <= RST_COLUMN;
            r_led_hold     <= '0;
        end else if (i_cmd.commit) begin
            r_square_prev  <= now_sq;
            r_combo_prev   <= combo;
            r_alone_prev   <= alone;
            r_long_seen    <= n_long_seen;
            r_minus_prev   <= n_minus_prev;
            r_plus_prev    <= n_plus_prev;
            r_mute_latched <= n_mute_latched;
            r_mute_on      <= n_mute_on;
            r_menu_latched <= n_menu_latched;
            r_menu_on      <= n_menu_on;
            r_bend_on      <= n_bend_on;
            r_combo_start  <= n_combo_start;
            r_alone_start  <= n_alone_start;
            r_column       <= n_column;
            r_led_hold     <= level;
        end
    end

    // Output beat register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.mute_state    <= n_mute_on;
            r_out.menu_state    <= n_menu_on;
            r_out.bend_state    <= n_bend_on;
            r_out.haptic_column <= n_column;
            r_out.led_level     <= level;
            r_out.led_write     <= wr;
            r_out.mute_toggled  <= mt;
            r_out.menu_toggled  <= nt;
            r_out.bend_toggled  <= bt;
        end
    end

    assign o_out_data = r_out;

endmodule

>>> tb/sv/bgm_gesture_checker.sv
// Checker for the button gesture controller: predicts each scan result and compares it.
module bgm_gesture_checker import bgm_pkg::*; #(
    parameter int MAX_COLUMN = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_in_beat             i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_out_beat            i_out_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Register copy
    logic [15:0]        combo_hold;
    logic [15:0]        alone_hold;
    logic [11:0]        on_ms;
    logic [11:0]        blink_gap;
    logic [13:0]        rest_len;
    logic [LEVEL_W-1:0] held_lvl;
    logic [LEVEL_W-1:0] glow_lvl;
    logic [LEVEL_W-1:0] rest_lvl;

    // Gesture state copy
    logic                square_prev, long_seen, minus_prev, plus_prev;
    logic                combo_prev, mute_latched, mute_on, alone_prev, menu_latched;
    logic                menu_on, bend_on;
    logic [TIME_W-1:0]   combo_start, alone_start;
    logic [COLUMN_W-1:0] column_reg;
    logic [LEVEL_W-1:0]  led_hold;

    // Results still owed by the block, oldest first
    t_out_beat expected_results[$];
    t_out_beat want;

    // Saturating haptics column step
    function automatic logic [COLUMN_W-1:0] column_step(input logic [COLUMN_W-1:0] col,
                                                        input bit up);
        int n;
        n = col;
        if (up)
            n = n + 1;
        else
            n = (n > 1) ? n - 1 : 1;
        if (n < 1)
            n = 1;
        if (n > MAX_COLUMN)
            n = MAX_COLUMN;
        return COLUMN_W'(n);
    endfunction

    // Mute pattern: blink, blink, rest
    function automatic logic [LEVEL_W-1:0] blink_level(input logic [TIME_W-1:0] now);
        int unsigned pair_len, period, phase;
        pair_len = on_ms + blink_gap;
        period   = 2 * pair_len + rest_len;
        phase    = (period != 0) ? now % period : 0;
        if (phase < pair_len)
            return (phase < on_ms) ? held_lvl : '0;
        phase = phase - pair_len;
        if (phase < pair_len)
            return (phase < on_ms) ? held_lvl : '0;
        return rest_lvl;
    endfunction

    // One scan tick through the gesture logic
    function automatic t_out_beat gesture_step(input t_in_beat b);
        t_out_beat          r;
        logic               combo, alone;
        logic [TIME_W-1:0]  now, held_for;
        logic [LEVEL_W-1:0] level;
        combo = b.circle_btn & b.square_btn;
        alone = b.square_btn & ~b.circle_btn;
        now   = b.time_ms;
        level = led_hold;
        r     = '0;
        if (b.game_active) begin
            // only the edge trackers move
            square_prev = b.square_btn;
            combo_prev  = combo;
            alone_prev  = alone;
        end else begin
            if (b.square_btn && !square_prev)
                long_seen = 1'b0;

            // two-button combo toggles mute once per hold
            if (combo && !combo_prev) begin
                combo_start  = now;
                mute_latched = 1'b0;
            end
            if (combo) begin
                long_seen = 1'b1;
                held_for  = now - combo_start;
                if (!mute_latched && held_for >= combo_hold) begin
                    mute_latched   = 1'b1;
                    mute_on        = ~mute_on;
                    r.mute_toggled = 1'b1;
                end
            end
            combo_prev = combo;

            // square alone: menu hold and column steps
            if (alone && !alone_prev) begin
                alone_start  = now;
                menu_latched = 1'b0;
            end
            if (alone && !mute_on) begin
                held_for = now - alone_start;
                if (!menu_latched && held_for >= alone_hold) begin
                    menu_latched   = 1'b1;
                    long_seen      = 1'b1;
                    menu_on        = ~menu_on;
                    r.menu_toggled = 1'b1;
                end
                if (b.minus_pressed && !minus_prev)
                    column_reg = column_step(column_reg, 1'b0);
                if (b.plus_pressed && !plus_prev)
                    column_reg = column_step(column_reg, 1'b1);
                minus_prev = b.minus_pressed;
                plus_prev  = b.plus_pressed;
            end
            alone_prev = alone;

            // short click flips pitch bend
            if (!b.square_btn && square_prev && !long_seen && !mute_on) begin
                bend_on        = ~bend_on;
                r.bend_toggled = 1'b1;
            end

            if (mute_on)
                level = blink_level(now);
            else if (combo || b.square_btn)
                level = held_lvl;
            else
                level = bend_on ? glow_lvl : '0;
            led_hold    = level;
            r.led_write = 1'b1;

            square_prev = b.square_btn;
        end
        r.mute_state    = mute_on;
        r.menu_state    = menu_on;
        r.bend_state    = bend_on;
        r.haptic_column = column_reg;
        r.led_level     = level;
        return r;
    endfunction

    // Field compare; only the first ten failures are printed
    function automatic void check(input string field, input int unsigned exp_val,
                                  input int unsigned act_val);
        if (exp_val != act_val) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h",
                         $realtime, field, exp_val, act_val);
        end
    endfunction

    // Watch config, input and output beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            combo_hold   = RST_COMBO_HOLD;
            alone_hold   = RST_ALONE_HOLD;
            on_ms        = RST_FLASH_ON;
            blink_gap    = RST_BLINK_GAP;
            rest_len     = RST_REST;
            held_lvl     = RST_HELD_LEVEL;
            glow_lvl     = RST_GLOW_LEVEL;
            rest_lvl     = RST_REST_LEVEL;
            {square_prev, long_seen, minus_prev, plus_prev} = '0;
            {combo_prev, mute_latched, mute_on, alone_prev, menu_latched} = '0;
            {menu_on, bend_on} = '0;
            combo_start  = '0;
            alone_start  = '0;
            column_reg   = RST_COLUMN;
            led_hold     = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_COMBO_HOLD: combo_hold = i_cfg_data;
                    CFG_ALONE_HOLD: alone_hold = i_cfg_data;
                    CFG_FLASH_ON:   on_ms      = i_cfg_data[11:0];
                    CFG_BLINK_GAP:  blink_gap  = i_cfg_data[11:0];
                    CFG_REST:       rest_len   = i_cfg_data[13:0];
                    CFG_HELD_LEVEL: held_lvl   = i_cfg_data[LEVEL_W-1:0];
                    CFG_GLOW_LEVEL: glow_lvl   = i_cfg_data[LEVEL_W-1:0];
                    CFG_REST_LEVEL: rest_lvl   = i_cfg_data[LEVEL_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: result beat with nothing expected, got %h",
                                 $realtime, i_out_data);
                end else begin
                    want = expected_results.pop_front();
                    check("mute_state",    want.mute_state,    i_out_data.mute_state);
                    check("menu_state",    want.menu_state,    i_out_data.menu_state);
                    check("bend_state",    want.bend_state,    i_out_data.bend_state);
                    check("haptic_column", want.haptic_column, i_out_data.haptic_column);
                    check("led_level",     want.led_level,     i_out_data.led_level);
                    check("led_write",     want.led_write,     i_out_data.led_write);
                    check("mute_toggled",  want.mute_toggled,  i_out_data.mute_toggled);
                    check("menu_toggled",  want.menu_toggled,  i_out_data.menu_toggled);
                    check("bend_toggled",  want.bend_toggled,  i_out_data.bend_toggled);
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(gesture_step(i_in_data));
        end
        o_pending = expected_results.size();
    end

endmodule

>>> tb/sv/tb_button_gesture_mode_controller.sv
// Testbench top for the button gesture controller: stimulus, register phases and verdict.
module tb_button_gesture_mode_controller;
    import bgm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COLUMN  = 6;
    localparam int STALL_LIMIT = 2000;  // cycles with no beat moving
    localparam int SETTLE      = 40;    // quiet cycles after the last result

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_beat             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_beat            o_out_data;

    int                   fail_count;
    int                   pending;
    int                   send_idle;
    int                   recv_idle;
    int                   tick_max;
    int                   beats_sent;
    int                   stall_cycles;
    logic [TIME_W-1:0]    scan_ms;
    logic [CFG_W-1:0]     reg_plan [8];

    button_gesture_mode_controller #(.MAX_COLUMN(MAX_COLUMN)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    bgm_gesture_checker #(.MAX_COLUMN(MAX_COLUMN)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver back-pressure
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Watchdog on beat movement
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb_button_gesture_mode_controller: errors");
                $finish;
            end
        end
    end

    function automatic bit coin();
        return 1'($urandom_range(0, 1));
    endfunction

    // Offer one scan beat; entered and left at a falling edge
    task automatic scan_at(input bit c, input bit s, input bit m, input bit p, input bit g,
                           input logic [TIME_W-1:0] t);
        t_in_beat b;
        scan_ms         = t;
        b.circle_btn    = c;
        b.square_btn    = s;
        b.minus_pressed = m;
        b.plus_pressed  = p;
        b.game_active   = g;
        b.time_ms       = t;
        if ($urandom_range(0, 99) < send_idle) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < send_idle);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        beats_sent++;
    endtask

    // Next tick with the clock moved on a random amount
    task automatic scan(input bit c, input bit s, input bit m, input bit p, input bit g);
        scan_at(c, s, m, p, g, scan_ms + $urandom_range(0, tick_max));
    endtask

    // Drop valid, wait for every result, then let the block go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Write all eight registers from reg_plan, one per cycle
    task automatic write_regs();
        for (int k = 0; k < 8; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(k);
            i_cfg_data <= reg_plan[k];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Mostly well-formed gestures with random timing, some noise
    task automatic run_gestures(input int until_beats);
        int n;
        while (beats_sent < until_beats) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    // both held, then released in some order
                    n = $urandom_range(1, 8);
                    repeat (n) scan(1, 1, coin(), coin(), 0);
                    case ($urandom_range(0, 2))
                        0: ;
                        1: repeat ($urandom_range(1, 3)) scan(0, 1, coin(), coin(), 0);
                        default: repeat ($urandom_range(1, 3)) scan(1, 0, 0, 0, 0);
                    endcase
                    scan(0, 0, 0, 0, 0);
                end
                2, 3: begin
                    // square alone with minus and plus taps
                    n = $urandom_range(1, 10);
                    repeat (n) scan(0, 1, coin(), coin(), 0);
                    scan(0, 0, 0, 0, 0);
                end
                4: begin
                    scan(0, 1, 0, 0, 0);
                    scan(0, 0, 0, 0, 0);
                end
                5: begin
                    repeat ($urandom_range(1, 4)) scan(coin(), coin(), coin(), coin(), 1);
                end
                6: begin
                    if ($urandom_range(0, 3) == 0)
                        scan_ms = $urandom;
                    scan(coin(), coin(), coin(), coin(), $urandom_range(0, 7) == 0);
                end
                7: begin
                    // combo straddling the timestamp wrap
                    scan_ms = 32'hFFFF_FFFF - $urandom_range(0, 4 * tick_max);
                    repeat ($urandom_range(2, 6)) scan(1, 1, 0, 0, 0);
                    scan(0, 0, 0, 0, 0);
                end
                default: begin
                    repeat ($urandom_range(1, 4)) scan(0, 0, 0, 0, 0);
                end
            endcase
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        send_idle  = 17;
        recv_idle  = 60;
        tick_max   = 0;
        beats_sent = 0;
        scan_ms    = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed ticks at reset register values
        scan_at(0, 0, 0, 0, 0, 32'd0);
        scan_at(0, 1, 0, 0, 0, 32'd10);       // click press: bend on at release
        scan_at(0, 0, 0, 0, 0, 32'd20);
        scan_at(1, 1, 0, 0, 0, 32'd100);      // combo starts
        scan_at(1, 1, 0, 0, 0, 32'd3099);     // one short of the hold
        scan_at(1, 1, 0, 0, 0, 32'd3100);     // mute on
        scan_at(0, 0, 0, 0, 0, 32'd3150);     // blink pattern
        scan_at(0, 1, 0, 0, 0, 32'd3200);
        scan_at(0, 1, 1, 1, 0, 32'd3210);     // muted: no column step
        scan_at(0, 0, 0, 0, 0, 32'd3300);     // muted: click ignored
        scan_at(1, 1, 0, 0, 0, 32'd4000);
        scan_at(1, 1, 0, 0, 0, 32'd7000);     // mute off
        scan_at(0, 1, 0, 0, 0, 32'd7100);     // square alone from combo
        scan_at(0, 1, 0, 1, 0, 32'd7200);
        scan_at(0, 1, 0, 0, 0, 32'd7300);
        scan_at(0, 1, 0, 1, 0, 32'd7400);     // column at top
        scan_at(0, 1, 0, 0, 0, 32'd7500);
        scan_at(0, 1, 0, 1, 0, 32'd10100);    // saturates, menu toggles
        scan_at(0, 1, 1, 0, 0, 32'd10200);
        scan_at(0, 0, 0, 0, 0, 32'd10300);    // long hold: no bend toggle
        scan_at(1, 1, 1, 1, 1, 32'd10400);    // game mode
        scan_at(0, 0, 0, 0, 1, 32'd10500);
        scan_at(1, 1, 0, 0, 0, 32'hFFFF_FF00);
        scan_at(1, 1, 0, 0, 0, 32'h0000_0B00); // wrapped hold: mute on
        scan_at(1, 1, 1, 1, 0, 32'hFFFF_FFFF);
        scan_at(0, 0, 0, 0, 0, 32'h0000_0000);

        // Short holds and a fast pattern
        settle();
        reg_plan[CFG_COMBO_HOLD] = 16'd40;
        reg_plan[CFG_ALONE_HOLD] = 16'd60;
        reg_plan[CFG_FLASH_ON]   = 16'd3;
        reg_plan[CFG_BLINK_GAP]  = 16'd2;
        reg_plan[CFG_REST]       = 16'd9;
        reg_plan[CFG_HELD_LEVEL] = 16'd200;
        reg_plan[CFG_GLOW_LEVEL] = 16'd77;
        reg_plan[CFG_REST_LEVEL] = 16'd33;
        write_regs();
        tick_max = 15;
        run_gestures(beats_sent + 145);

        // Top of the combo hold, pattern and glow/rest level ranges, idling swapped
        settle();
        send_idle = 60;
        recv_idle = 17;
        reg_plan[CFG_COMBO_HOLD] = 16'd65535;
        reg_plan[CFG_ALONE_HOLD] = 16'd1;
        reg_plan[CFG_FLASH_ON]   = 16'd4095;
        reg_plan[CFG_BLINK_GAP]  = 16'd4095;
        reg_plan[CFG_REST]       = 16'd16383;
        reg_plan[CFG_HELD_LEVEL] = 16'd0;
        reg_plan[CFG_GLOW_LEVEL] = 16'd255;
        reg_plan[CFG_REST_LEVEL] = 16'd255;
        write_regs();
        tick_max = 20000;
        run_gestures(beats_sent + 145);

        // Zero holds and a zero-length mute pattern, no idling
        settle();
        send_idle = 0;
        recv_idle = 0;
        reg_plan[CFG_COMBO_HOLD] = 16'd0;
        reg_plan[CFG_ALONE_HOLD] = 16'd0;
        reg_plan[CFG_FLASH_ON]   = 16'd0;
        reg_plan[CFG_BLINK_GAP]  = 16'd0;
        reg_plan[CFG_REST]       = 16'd0;
        reg_plan[CFG_HELD_LEVEL] = 16'd255;
        reg_plan[CFG_GLOW_LEVEL] = 16'd0;
        reg_plan[CFG_REST_LEVEL] = 16'd1;
        write_regs();
        tick_max = 5;
        run_gestures(beats_sent + 140);

        // Random values, over the full write width but for the holds, masked by the block
        settle();
        reg_plan[CFG_COMBO_HOLD] = 16'($urandom_range(1, 200));
        reg_plan[CFG_ALONE_HOLD] = 16'($urandom_range(1, 200));
        reg_plan[CFG_FLASH_ON]   = 16'($urandom);
        reg_plan[CFG_BLINK_GAP]  = 16'($urandom);
        reg_plan[CFG_REST]       = 16'($urandom);
        reg_plan[CFG_HELD_LEVEL] = 16'($urandom);
        reg_plan[CFG_GLOW_LEVEL] = 16'($urandom);
        reg_plan[CFG_REST_LEVEL] = 16'($urandom);
        write_regs();
        tick_max = 60;
        run_gestures(beats_sent + 145);

        settle();
        if (fail_count == 0) begin
            $display("tb_button_gesture_mode_controller: clean");
        end else begin
            $display("tb_button_gesture_mode_controller: errors");
        end
        $finish;
    end

endmodule
